// File: rtl/bitmap_run_allocator_macros.svh
// Assertion macros shared by the bitmap run allocator RTL.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies; used by bra_run_scan and bitmap_run_allocator.
package bra_pkg;

    localparam int MAX_BYTES_DEF = 128;
    localparam int IDX_W         = 10;  // bit_index and run_start
    localparam int LEN_W         = 11;  // run_length
    localparam int POS_W         = 11;  // bit position within the active map
    localparam int BYTE_W        = 8;   // active_bytes and byte counters

    localparam logic [BYTE_W-1:0] ACTIVE_BYTES_RESET = 8'd128;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_TEST  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_SCAN  = 2'd3
    } req_t;

    typedef struct packed {
        logic             init;   // restart the run search
        logic             step;   // one map byte is on the data input
        logic [LEN_W-1:0] len;    // requested run length
        logic [POS_W-1:0] base;   // bit position of bit 0 of the byte
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
    } scan_stat_t;

endpackage

// File: rtl/bra_map_mem.sv
// Usage bitmap storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module bra_map_mem #(
    parameter int MAX_BYTES = 128,
    parameter int AW        = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [MAX_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/bra_run_scan.sv
// Run tracker for the first-fit scan: takes one map byte per step and
// keeps the current free-run length and the first start found. Uses bra_pkg.
module bra_run_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bra_pkg::scan_ctl_t   ctl,
    input  logic [7:0]           byte_data,
    output bra_pkg::scan_stat_t  stat
);

    logic [bra_pkg::LEN_W-1:0] run_reg,   run_next;
    logic                      found_reg, found_next;
    logic [bra_pkg::POS_W-1:0] start_reg, start_next;

    always_comb
    begin
        run_next   = run_reg;
        found_next = found_reg;
        start_next = start_reg;
        if (ctl.init)
        begin
            run_next   = '0;
            found_next = 1'b0;
            start_next = '0;
        end
        else if (ctl.step && !found_reg)
        begin
            // walk the eight bits from the lowest up, stop at the first hit
            for (int j = 0; j < 8; j++)
            begin
                if (!found_next)
                begin
                    if (byte_data[j])
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = run_next + 1'b1;
                        if (run_next == ctl.len)
                        begin
                            found_next = 1'b1;
                            start_next = ctl.base + bra_pkg::POS_W'(j) + 1'b1
                                         - bra_pkg::POS_W'(ctl.len);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            found_reg <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            found_reg <= found_next;
            start_reg <= start_next;
        end
    end

    assign stat.found = found_reg;
    assign stat.start = start_reg;

endmodule

// File: rtl/bitmap_run_allocator.sv
// Bitmap run allocator over bra_map_mem and bra_run_scan (uses bra_pkg); live = active bytes
// capped at MAX_BYTES. In-range test/write reads the map byte, then tests or writes the bit;
// clear zeroes live bytes; scan reads one map byte per cycle through the read port; out-of-range
// test/write, rejected scan lengths and clear of an empty map go straight to the result. A new
// request waits until the last one is done; a result held in the output register stalls it.
// Reset: map swept to zero with s_tready low; active_bytes is 128.
`include "bitmap_run_allocator_macros.svh"

module bitmap_run_allocator #(
    parameter int MAX_BYTES = bra_pkg::MAX_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,   // active_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [9:0] bit_index, [10] bit_value, [21:11] run_length
    input  logic [1:0]  s_tuser,     // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [9:0] run_start, [10] bit_was_set
    output logic        m_tuser      // [0] status
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [bra_pkg::BYTE_W-1:0] LiveCap =
        (MAX_BYTES > 255) ? 8'd255 : 8'(MAX_BYTES);
    localparam logic [AW-1:0] LastAddr = AW'(MAX_BYTES - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_BIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                          state_reg,  state_next;
    logic [bra_pkg::BYTE_W-1:0]      active_reg, active_next;
    bra_pkg::req_t                   req_reg,    req_next;
    logic [bra_pkg::IDX_W-1:0]       idx_reg,    idx_next;
    logic                            val_reg,    val_next;
    logic [bra_pkg::LEN_W-1:0]       len_reg,    len_next;
    logic [AW-1:0]                   init_reg,   init_next;
    logic [bra_pkg::BYTE_W-1:0]      cnt_reg,    cnt_next;   // clear and read issue
    logic [bra_pkg::BYTE_W-1:0]      proc_reg,   proc_next;
    logic                            pend_reg,   pend_next;
    logic                            rs_reg,     rs_next;    // result status
    logic [bra_pkg::IDX_W-1:0]       rstart_reg, rstart_next;
    logic                            rwas_reg,   rwas_next;
    logic                            mv_reg,     mv_next;
    logic                            ms_reg,     ms_next;
    logic [bra_pkg::IDX_W-1:0]       mstart_reg, mstart_next;
    logic                            mwas_reg,   mwas_next;

    logic [bra_pkg::BYTE_W-1:0] live;
    logic [bra_pkg::POS_W-1:0]  nbits;
    logic                       s_xfer;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [7:0]                 mem_wdata, mem_rdata;
    logic [7:0]                 bit_mask;
    bra_pkg::scan_ctl_t         scan_ctl;
    bra_pkg::scan_stat_t        scan_stat;

    assign live     = (active_reg > LiveCap) ? LiveCap : active_reg;
    assign nbits    = {live, 3'b000};
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign bit_mask = 8'b1 << idx_reg[2:0];

    assign scan_ctl.init = s_xfer;
    assign scan_ctl.step = (state_reg == ST_SCAN) && pend_reg;
    assign scan_ctl.len  = len_reg;
    assign scan_ctl.base = {proc_reg, 3'b000};

    bra_map_mem #(
        .MAX_BYTES (MAX_BYTES),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bra_run_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .byte_data (mem_rdata),
        .stat      (scan_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        active_next = cfg_we ? cfg_wdata : active_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        len_next    = len_reg;
        init_next   = init_reg;
        cnt_next    = cnt_reg;
        proc_next   = proc_reg;
        pend_next   = pend_reg;
        rs_next     = rs_reg;
        rstart_next = rstart_reg;
        rwas_next   = rwas_reg;
        mv_next     = mv_reg;
        ms_next     = ms_reg;
        mstart_next = mstart_reg;
        mwas_next   = mwas_reg;
        mem_we      = 1'b0;
        mem_waddr   = AW'(cnt_reg);
        mem_wdata   = 8'h00;
        mem_re      = 1'b0;
        mem_raddr   = AW'(idx_reg[bra_pkg::IDX_W-1:3]);

        // drop the output once the downstream side takes it
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_reg;
                init_next = init_reg + 1'b1;
                if (init_reg == LastAddr)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    req_next    = bra_pkg::req_t'(s_tuser);
                    idx_next    = s_tdata[9:0];
                    val_next    = s_tdata[10];
                    len_next    = s_tdata[21:11];
                    rs_next     = 1'b0;
                    rstart_next = '0;
                    rwas_next   = 1'b0;
                    cnt_next    = '0;
                    proc_next   = '0;
                    pend_next   = 1'b0;
                    case (bra_pkg::req_t'(s_tuser))
                        bra_pkg::REQ_CLEAR:
                            state_next = (live == '0) ? ST_DONE : ST_CLEAR;
                        bra_pkg::REQ_TEST, bra_pkg::REQ_WRITE:
                            state_next = ({1'b0, s_tdata[9:0]} < nbits) ? ST_READ : ST_DONE;
                        bra_pkg::REQ_SCAN:
                        begin
                            if (s_tdata[21:11] == '0 || s_tdata[21:11] > nbits)
                            begin
                                rs_next    = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == live - 1'b1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_BIT;
            end
            ST_BIT:
            begin
                // the write lands before any later request can issue a read
                if (req_reg == bra_pkg::REQ_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(idx_reg[bra_pkg::IDX_W-1:3]);
                    mem_wdata = val_reg ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
                end
                else
                begin
                    rwas_next = mem_rdata[idx_reg[2:0]];
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                mem_raddr = AW'(cnt_reg);
                if (cnt_reg != live)
                begin
                    mem_re    = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    proc_next = proc_reg + 1'b1;
                end
                if (scan_stat.found)
                begin
                    rs_next     = 1'b0;
                    rstart_next = scan_stat.start[bra_pkg::IDX_W-1:0];
                    state_next  = ST_DONE;
                end
                else if (!pend_reg && proc_reg == live)
                begin
                    rs_next    = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next     = 1'b1;
                    ms_next     = rs_reg;
                    mstart_next = rstart_reg;
                    mwas_next   = rwas_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            active_reg <= bra_pkg::ACTIVE_BYTES_RESET;
            req_reg    <= bra_pkg::REQ_CLEAR;
            idx_reg    <= '0;
            val_reg    <= 1'b0;
            len_reg    <= '0;
            init_reg   <= '0;
            cnt_reg    <= '0;
            proc_reg   <= '0;
            pend_reg   <= 1'b0;
            rs_reg     <= 1'b0;
            rstart_reg <= '0;
            rwas_reg   <= 1'b0;
            mv_reg     <= 1'b0;
            ms_reg     <= 1'b0;
            mstart_reg <= '0;
            mwas_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            req_reg    <= req_next;
            idx_reg    <= idx_next;
            val_reg    <= val_next;
            len_reg    <= len_next;
            init_reg   <= init_next;
            cnt_reg    <= cnt_next;
            proc_reg   <= proc_next;
            pend_reg   <= pend_next;
            rs_reg     <= rs_next;
            rstart_reg <= rstart_next;
            rwas_reg   <= rwas_next;
            mv_reg     <= mv_next;
            ms_reg     <= ms_next;
            mstart_reg <= mstart_next;
            mwas_reg   <= mwas_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = ms_reg;
    assign m_tdata  = {5'b00000, mwas_reg, mstart_reg};

    `BRA_ASSERT_NOW(a_no_write_in_scan, state_reg == ST_SCAN, !mem_we, "map written during scan")
    `BRA_ASSERT_NOW(a_notfound_clean, m_tvalid && m_tuser, m_tdata[10:0] == 11'd0, "not-found result carries data")
    `BRA_ASSERT_NOW(a_init_blocks_input, state_reg == ST_INIT, !s_tready, "input taken during map sweep")
    `BRA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second request taken while one is in work")

endmodule
